// ===== rtl/core/kwl_pkg.sv =====
package kwl_pkg;

    localparam int POS_W = 16;
    localparam int OUT_W = 16;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam int QDEPTH = 4;
    localparam int QPW = $clog2(QDEPTH);

    localparam logic [3:0] K_INVALID = 4'd0;
    localparam logic [3:0] K_DARLING = 4'd1;
    localparam logic [3:0] K_MY      = 4'd2;
    localparam logic [3:0] K_NOTHING = 4'd3;
    localparam logic [3:0] K_BEATS   = 4'd4;
    localparam logic [3:0] K_A       = 4'd5;
    localparam logic [3:0] K_JET     = 4'd6;
    localparam logic [3:0] K_HAND    = 4'd7;
    localparam logic [3:0] K_HOLD    = 4'd8;
    localparam logic [3:0] K_HOLIDAY = 4'd9;
    localparam logic [3:0] K_END     = 4'd10;

    localparam logic [4:0] P_IDLE    = 5'd0;
    localparam logic [4:0] P_DARLING = 5'd1;
    localparam logic [4:0] P_MY      = 5'd7;
    localparam logic [4:0] P_NOTHING = 5'd8;
    localparam logic [4:0] P_BEATS   = 5'd14;
    localparam logic [4:0] P_JET     = 5'd18;
    localparam logic [4:0] P_HAND    = 5'd21;
    localparam logic [4:0] P_HOLIDAY = 5'd23;
    localparam logic [4:0] P_H1      = 5'd26;
    localparam logic [4:0] P_H2      = 5'd27;
    localparam logic [4:0] P_H3      = 5'd28;
    localparam logic [4:0] P_AWAIT   = 5'd29;

    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [3:0]       token_kind;
        logic [OUT_W-1:0] token_line;
        logic [OUT_W-1:0] token_column;
        logic             last_of_run;
    } out_t;

    typedef struct packed {
        logic [3:0]       kind;
        logic [OUT_W-1:0] line;
        logic [OUT_W-1:0] column;
    } res_t;

    // results of one input transfer: r0 always, r1 when second is set
    typedef struct packed {
        logic second;
        res_t r0;
        res_t r1;
    } pair_t;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        sat_inc = (v == POS_MAX) ? v : POS_W'(v + 1'b1);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [POS_W-1:0] v);
        to_out = OUT_W'(v);
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        is_delim = (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) ||
                   (b == CH_LF) || (b == CH_SEMI);
    endfunction

    // expected byte at each linear trie position
    function automatic logic [7:0] chain_byte(input logic [4:0] p);
        unique case (p)
            5'd1:    chain_byte = "a";
            5'd2:    chain_byte = "r";
            5'd3:    chain_byte = "l";
            5'd4:    chain_byte = "i";
            5'd5:    chain_byte = "n";
            5'd6:    chain_byte = "g";
            5'd7:    chain_byte = "y";
            5'd8:    chain_byte = "o";
            5'd9:    chain_byte = "t";
            5'd10:   chain_byte = "h";
            5'd11:   chain_byte = "i";
            5'd12:   chain_byte = "n";
            5'd13:   chain_byte = "g";
            5'd14:   chain_byte = "e";
            5'd15:   chain_byte = "a";
            5'd16:   chain_byte = "t";
            5'd17:   chain_byte = "s";
            5'd18:   chain_byte = "e";
            5'd19:   chain_byte = "t";
            5'd20:   chain_byte = "2";
            5'd21:   chain_byte = "n";
            5'd22:   chain_byte = "d";
            5'd23:   chain_byte = "d";
            5'd24:   chain_byte = "a";
            5'd25:   chain_byte = "y";
            default: chain_byte = 8'h00;
        endcase
    endfunction

    // keyword completed when the expected byte at this position matches
    function automatic logic [3:0] chain_kind(input logic [4:0] p);
        unique case (p)
            5'd6:    chain_kind = K_DARLING;
            5'd7:    chain_kind = K_MY;
            5'd13:   chain_kind = K_NOTHING;
            5'd17:   chain_kind = K_BEATS;
            5'd20:   chain_kind = K_JET;
            5'd22:   chain_kind = K_HAND;
            5'd25:   chain_kind = K_HOLIDAY;
            default: chain_kind = K_INVALID;
        endcase
    endfunction

endpackage

// ===== rtl/core/kwl_front.sv =====
module kwl_front import kwl_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_fire,
    input  in_t   in_data,
    output logic  push,
    output pair_t push_data
);

    logic [4:0]       mp_reg, mp_next;
    logic             comment_reg, comment_next;
    logic [POS_W-1:0] line_reg, line_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [3:0]       pend_reg, pend_next;

    logic [7:0]       b;
    logic [POS_W-1:0] col_inc;
    logic             in_match;

    // idle-byte handling, shared by the idle and keyword-await paths
    logic [4:0]       ib_mp;
    logic [3:0]       ib_pend;
    logic             ib_comment;
    logic [POS_W-1:0] ib_line;
    logic [POS_W-1:0] ib_col;
    logic [POS_W-1:0] ib_start;
    logic             ib_emit;
    res_t             ib_res;

    logic             st_ok;
    logic [4:0]       st_next;
    logic [3:0]       st_kind;

    logic [POS_W-1:0] end_line;
    logic [POS_W-1:0] end_col;

    assign b        = in_data.byte_in;
    assign col_inc  = sat_inc(col_reg);
    assign in_match = (mp_reg >= P_DARLING) && (mp_reg <= P_H3);

    always_comb begin
        ib_mp      = P_IDLE;
        ib_pend    = K_INVALID;
        ib_comment = 1'b0;
        ib_line    = line_reg;
        ib_col     = col_inc;
        ib_start   = start_reg;
        ib_emit    = 1'b0;
        if (b == CH_SEMI) begin
            ib_comment = 1'b1;
        end else if (b == CH_LF) begin
            ib_line = sat_inc(line_reg);
            ib_col  = '0;
        end else if (b == CH_SP || b == CH_TAB || b == CH_CR) begin
            ib_emit = 1'b0;
        end else begin
            ib_start = col_inc;
            unique case (b)
                "d":     ib_mp = P_DARLING;
                "m":     ib_mp = P_MY;
                "n":     ib_mp = P_NOTHING;
                "b":     ib_mp = P_BEATS;
                "j":     ib_mp = P_JET;
                "h":     ib_mp = P_H1;
                "a": begin
                    ib_mp   = P_AWAIT;
                    ib_pend = K_A;
                end
                default: ib_emit = 1'b1;
            endcase
        end
        ib_res.kind   = K_INVALID;
        ib_res.line   = to_out(line_reg);
        ib_res.column = to_out(col_inc);
    end

    // one trie step for a byte inside a keyword
    always_comb begin
        st_ok   = 1'b1;
        st_next = P_IDLE;
        st_kind = K_INVALID;
        if (mp_reg == P_H1) begin
            if (b == "a") begin
                st_next = P_HAND;
            end else if (b == "o") begin
                st_next = P_H2;
            end else begin
                st_ok = 1'b0;
            end
        end else if (mp_reg == P_H2) begin
            if (b == "l") begin
                st_next = P_H3;
            end else begin
                st_ok = 1'b0;
            end
        end else if (mp_reg == P_H3) begin
            if (b == "d") begin
                st_next = P_AWAIT;
                st_kind = K_HOLD;
            end else if (b == "i") begin
                st_next = P_HOLIDAY;
            end else begin
                st_ok = 1'b0;
            end
        end else if (b == chain_byte(mp_reg)) begin
            st_kind = chain_kind(mp_reg);
            st_next = (st_kind != K_INVALID) ? P_AWAIT : 5'(mp_reg + 5'd1);
        end else begin
            st_ok = 1'b0;
        end
    end

    always_comb begin
        mp_next      = mp_reg;
        comment_next = comment_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        start_next   = start_reg;
        pend_next    = pend_reg;
        push         = 1'b0;
        end_line     = line_reg;
        end_col      = col_inc;

        push_data.second    = 1'b0;
        push_data.r0.kind   = K_INVALID;
        push_data.r0.line   = to_out(line_reg);
        push_data.r0.column = to_out(start_reg);
        push_data.r1        = ib_res;

        if (in_fire) begin
            if (in_data.end_of_input) begin
                if (comment_reg) begin
                    end_line = sat_inc(line_reg);
                    end_col  = sat_inc('0);
                end else if (in_match) begin
                    push_data.second = 1'b1;
                    end_col          = sat_inc(col_inc);
                end else if (mp_reg == P_AWAIT) begin
                    push_data.second  = 1'b1;
                    push_data.r0.kind = pend_reg;
                end
                if (push_data.second) begin
                    push_data.r1.kind   = K_END;
                    push_data.r1.line   = to_out(end_line);
                    push_data.r1.column = to_out(end_col);
                end else begin
                    push_data.r0.kind   = K_END;
                    push_data.r0.line   = to_out(end_line);
                    push_data.r0.column = to_out(end_col);
                end
                push         = 1'b1;
                mp_next      = P_IDLE;
                comment_next = 1'b0;
                line_next    = POS_W'(1);
                col_next     = '0;
                start_next   = '0;
                pend_next    = K_INVALID;
            end else if (comment_reg) begin
                col_next = col_inc;
                if (b == CH_LF) begin
                    line_next    = sat_inc(line_reg);
                    col_next     = '0;
                    comment_next = 1'b0;
                end
            end else if (mp_reg == P_AWAIT) begin
                // keyword stands only if a delimiter follows it
                push              = 1'b1;
                push_data.r0.kind = is_delim(b) ? pend_reg : K_INVALID;
                push_data.second  = ib_emit;
                mp_next           = ib_mp;
                pend_next         = ib_pend;
                comment_next      = ib_comment;
                line_next         = ib_line;
                col_next          = ib_col;
                start_next        = ib_start;
            end else if (in_match) begin
                col_next = col_inc;
                if (!st_ok) begin
                    push    = 1'b1;
                    mp_next = P_IDLE;
                end else begin
                    mp_next = st_next;
                    if (st_next == P_AWAIT) begin
                        pend_next = st_kind;
                    end
                end
            end else begin
                push         = ib_emit;
                push_data.r0 = ib_res;
                mp_next      = ib_mp;
                pend_next    = ib_pend;
                comment_next = ib_comment;
                line_next    = ib_line;
                col_next     = ib_col;
                start_next   = ib_start;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mp_reg      <= P_IDLE;
            comment_reg <= 1'b0;
            line_reg    <= POS_W'(1);
            col_reg     <= '0;
            start_reg   <= '0;
            pend_reg    <= K_INVALID;
        end else begin
            mp_reg      <= mp_next;
            comment_reg <= comment_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            start_reg   <= start_next;
            pend_reg    <= pend_next;
        end
    end

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_data.end_of_input |=>
            mp_reg == P_IDLE && line_reg == POS_W'(1) && col_reg == '0 && !comment_reg)
        else $error("lexer state not cleared after end marker");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line counter reached zero");

endmodule

// ===== rtl/core/kwl_queue.sv =====
module kwl_queue import kwl_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  pair_t push_data,
    output logic  not_full,
    output logic  m_valid,
    input  logic  m_ready,
    output out_t  m_data
);

    pair_t          mem [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPW:0]   count_reg, count_next;
    logic           sub_reg, sub_next;

    pair_t head;
    logic  out_xfer;
    logic  pop;

    assign head     = mem[rd_ptr_reg];
    assign not_full = (count_reg != (QPW+1)'(QDEPTH));
    assign m_valid  = (count_reg != '0);
    assign out_xfer = m_valid && m_ready;
    // an entry leaves after its last result is transferred
    assign pop      = out_xfer && (sub_reg || !head.second);

    always_comb begin
        m_data.token_kind   = sub_reg ? head.r1.kind   : head.r0.kind;
        m_data.token_line   = sub_reg ? head.r1.line   : head.r0.line;
        m_data.token_column = sub_reg ? head.r1.column : head.r0.column;
        m_data.last_of_run  = sub_reg || !head.second;
    end

    always_comb begin
        wr_ptr_next = push ? QPW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = (QPW+1)'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = (QPW+1)'(count_reg - 1'b1);
        end
        sub_next = sub_reg;
        if (pop) begin
            sub_next = 1'b0;
        end else if (out_xfer) begin
            sub_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> not_full)
        else $error("push into full queue");

    a_sub_has_second: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> m_valid && head.second)
        else $error("second result selected without one");

endmodule

// ===== rtl/core/keyword_lexer_with_position.sv =====
// results of a transfer on s_ are written into the queue and offered on m_ from its registers
// throughput: one source byte per cycle while the queue is not full; the lexer takes each byte as it is transferred
// results leave one per cycle while m_ready is high, so a byte that yields two results
// presents them in turn; a queue of 4 result pairs decouples the two sides
// reset: aresetn low (synchronous) returns to line 1, column 0 and empties the queue
module keyword_lexer_with_position import kwl_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic  in_fire;
    logic  push;
    pair_t push_data;
    logic  not_full;

    assign s_ready = not_full;
    assign in_fire = s_valid && s_ready;

    kwl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_data   (s_data),
        .push      (push),
        .push_data (push_data)
    );

    kwl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .not_full  (not_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
